### hdl/dfc_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal to float48 converter.
// Used by dfc_ctrl, dfc_dp and decimal_to_float48_converter; depends on nothing.
package dfc_pkg;

    localparam int FRACTION_BITS      = 36;
    localparam int MAX_DECIMAL_DIGITS = 9;
    localparam int EXP_W              = 11;
    localparam int WORD_W             = FRACTION_BITS + EXP_W + 1;
    localparam int WHOLE_W            = 32;
    localparam int FVAL_W             = 30;
    localparam int DIGITS_W           = 4;
    localparam int CNT_W              = $clog2(FRACTION_BITS);
    localparam int WBITS_W            = $clog2(WHOLE_W);
    localparam int SEXP_W             = 7;
    localparam int BEXP_W             = EXP_W + 2;
    localparam logic [EXP_W-1:0] EXP_BIAS_RESET = EXP_W'(1023);
    localparam logic [EXP_W-1:0] EXP_MAX        = {EXP_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an input beat
        logic norm_step;  // one normalization step
        logic frac_step;  // produce one fraction bit
        logic pack;       // assemble the output word
        logic zero;       // pack an all-zero word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_zero;
        logic norm_done;
        logic frac_last;
    } t_sts;

    function automatic logic [FVAL_W-1:0] pow10(input logic [DIGITS_W-1:0] d);
        logic [FVAL_W-1:0] v;
        case (d)
            4'd0:    v = FVAL_W'(1);
            4'd1:    v = FVAL_W'(10);
            4'd2:    v = FVAL_W'(100);
            4'd3:    v = FVAL_W'(1000);
            4'd4:    v = FVAL_W'(10000);
            4'd5:    v = FVAL_W'(100000);
            4'd6:    v = FVAL_W'(1000000);
            4'd7:    v = FVAL_W'(10000000);
            4'd8:    v = FVAL_W'(100000000);
            default: v = FVAL_W'(1000000000);
        endcase
        return v;
    endfunction

endpackage

### hdl/dfc_dp.sv
// Datapath of the decimal to float48 converter: operand registers, doubling unit,
// normalizer shift, fraction shift register and output word. Depends on dfc_pkg.
module dfc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dfc_pkg::t_cmd                 i_cmd,
    output dfc_pkg::t_sts                 o_sts,
    input  logic                          i_negative,
    input  logic [dfc_pkg::WHOLE_W-1:0]   i_whole_part,
    input  logic [dfc_pkg::FVAL_W-1:0]    i_fraction_value,
    input  logic [dfc_pkg::DIGITS_W-1:0]  i_fraction_digits,
    input  logic                          i_cfg_wr_en,
    input  logic [dfc_pkg::EXP_W-1:0]     i_cfg_wr_data,
    output logic [dfc_pkg::WORD_W-1:0]    o_float_word
);
    import dfc_pkg::*;

    logic [EXP_W-1:0]         r_bias;
    logic                     r_neg;
    logic                     r_is_whole;
    logic [WHOLE_W-1:0]       r_whole;
    logic [WBITS_W-1:0]       r_wbits;
    logic [FVAL_W-1:0]        r_rem;
    logic [FVAL_W-1:0]        r_scale;
    logic signed [SEXP_W-1:0] r_exp;
    logic [FRACTION_BITS-1:0] r_frac;
    logic [CNT_W-1:0]         r_cnt;
    logic [WORD_W-1:0]        r_word;

    logic [DIGITS_W-1:0]      digits_sat;
    logic [FVAL_W-1:0]        scale_in;
    logic [FVAL_W-1:0]        fval_clamped;
    logic [FVAL_W:0]          dbl_x;
    logic                     dbl_bit;
    logic [FVAL_W-1:0]        dbl_rem;
    logic                     whole_src;
    logic                     frac_bit;
    logic signed [BEXP_W-1:0] biased;
    logic [EXP_W-1:0]         exp_sat;

    // Saturate the digit count, look up the scale and clamp the numerator.
    always_comb begin
        digits_sat   = (i_fraction_digits > DIGITS_W'(MAX_DECIMAL_DIGITS))
                     ? DIGITS_W'(MAX_DECIMAL_DIGITS) : i_fraction_digits;
        scale_in     = pow10(digits_sat);
        fval_clamped = (i_fraction_value >= scale_in) ? scale_in - FVAL_W'(1)
                                                      : i_fraction_value;
    end

    // One doubling step of the remainder against the scale.
    always_comb begin
        dbl_x   = {r_rem, 1'b0};
        dbl_bit = (dbl_x >= {1'b0, r_scale});
        dbl_rem = dbl_bit ? FVAL_W'(dbl_x - {1'b0, r_scale}) : dbl_x[FVAL_W-1:0];
    end

    assign whole_src = (r_wbits != '0);
    assign frac_bit  = whole_src ? r_whole[WHOLE_W-2] : dbl_bit;

    always_comb begin
        biased = $signed({2'b00, r_bias}) + BEXP_W'(r_exp);
        if (biased < 0) begin
            exp_sat = '0;
        end else if (biased > $signed({2'b00, EXP_MAX})) begin
            exp_sat = EXP_MAX;
        end else begin
            exp_sat = biased[EXP_W-1:0];
        end
    end

    assign o_sts.is_zero   = (r_whole == '0) && (r_rem == '0);
    assign o_sts.norm_done = r_is_whole ? r_whole[WHOLE_W-1] : dbl_bit;
    assign o_sts.frac_last = (r_cnt == CNT_W'(FRACTION_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= EXP_BIAS_RESET;
        end else if (i_cfg_wr_en) begin
            r_bias <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg      <= i_negative;
            r_is_whole <= (i_whole_part != '0);
            r_whole    <= i_whole_part;
            r_wbits    <= (i_whole_part != '0) ? WBITS_W'(WHOLE_W - 1) : '0;
            r_exp      <= (i_whole_part != '0) ? SEXP_W'(WHOLE_W - 1) : '0;
            r_rem      <= fval_clamped;
            r_scale    <= scale_in;
            r_cnt      <= '0;
        end else if (i_cmd.norm_step) begin
            if (r_is_whole) begin
                // shift toward the leading one
                if (!r_whole[WHOLE_W-1]) begin
                    r_whole <= {r_whole[WHOLE_W-2:0], 1'b0};
                    r_wbits <= r_wbits - WBITS_W'(1);
                    r_exp   <= r_exp - SEXP_W'(1);
                end
            end else begin
                r_rem <= dbl_rem;
                r_exp <= r_exp - SEXP_W'(1);
            end
        end else if (i_cmd.frac_step) begin
            r_frac <= {r_frac[FRACTION_BITS-2:0], frac_bit};
            r_cnt  <= r_cnt + CNT_W'(1);
            if (whole_src) begin
                r_whole <= {r_whole[WHOLE_W-2:0], 1'b0};
                r_wbits <= r_wbits - WBITS_W'(1);
            end else begin
                r_rem <= dbl_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pack) begin
            r_word <= i_cmd.zero ? '0 : {r_neg, exp_sat, r_frac};
        end
    end

    assign o_float_word = r_word;

endmodule

### hdl/dfc_ctrl.sv
// Controller of the decimal to float48 converter: sequencing state machine and
// output beat valid. Depends on dfc_pkg.
module dfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  dfc_pkg::t_sts i_sts,
    output dfc_pkg::t_cmd o_cmd
);
    import dfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_NORM,
        S_FRAC,
        S_PACK
    } t_state;

    t_state r_state, n_state;
    logic   r_zero, n_zero;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.zero  = r_zero;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_zero  = i_sts.is_zero;
                n_state = i_sts.is_zero ? S_PACK : S_NORM;
            end
            S_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_sts.norm_done) begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                o_cmd.frac_step = 1'b1;
                if (i_sts.frac_last) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.pack  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_pack_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pack |=> r_out_valid)
        else $error("packed word not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.pack && r_out_valid && i_out_stall))
        else $error("output word overwritten while stalled");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK))
        else $error("accepted beat not sequenced");

endmodule

### hdl/decimal_to_float48_converter.sv
// Top level of the decimal to float48 converter: joins controller and datapath.
// Depends on dfc_pkg, dfc_ctrl and dfc_dp.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | negative, whole_part, fraction_value,
//          |           |                          | fraction_digits
//  out     | output    | o_out_valid / i_out_stall| float_word
//  cfg     | input     | i_cfg_wr_en              | exponent_bias (i_cfg_wr_data)
//
// One beat at a time: accept, classify, normalize steps (one shift of the whole part or
// one doubling of the fraction remainder each, the last one finding the leading one),
// the 36 fraction bits, one per step, and a pack step; a zero beat skips straight from
// classify to pack. The doubling unit is shared by the normalize and fraction steps.
// Synchronous active-low reset clears the sequencer, the output valid and sets the
// exponent bias to 1023. The finished word sits in an output register; the input side
// is stalled while a beat is in work, and a new beat may be taken while the previous
// word still waits under i_out_stall. Packing waits only if that word is still held.
module decimal_to_float48_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_negative,
    input  logic [dfc_pkg::WHOLE_W-1:0]   i_whole_part,
    input  logic [dfc_pkg::FVAL_W-1:0]    i_fraction_value,
    input  logic [dfc_pkg::DIGITS_W-1:0]  i_fraction_digits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dfc_pkg::WORD_W-1:0]    o_float_word,
    input  logic                          i_cfg_wr_en,
    input  logic [dfc_pkg::EXP_W-1:0]     i_cfg_wr_data
);
    import dfc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the conversion and drive both handshakes.
    dfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Hold operands, run the doubling and shift steps, pack the word.
    dfc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_negative        (i_negative),
        .i_whole_part      (i_whole_part),
        .i_fraction_value  (i_fraction_value),
        .i_fraction_digits (i_fraction_digits),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_float_word      (o_float_word)
    );

endmodule
